/* rtl/wpdt_pkg.sv */
// Package with the shared types and constants of the wheel pulse distance timer.
`timescale 1ns / 1ps

package wpdt_pkg;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [1:0] REG_PPM     = 2'd0;
  localparam logic [1:0] REG_TARGET  = 2'd1;
  localparam logic [1:0] REG_CMAX    = 2'd2;
  localparam logic [1:0] REG_RESTART = 2'd3;

  // Register reset values.
  localparam logic [7:0]  PPM_RST     = 8'd45;
  localparam logic [11:0] TARGET_RST  = 12'd400;
  localparam logic [15:0] CMAX_RST    = 16'd4095;
  localparam logic [15:0] RESTART_RST = 16'd2048;

  // Input function codes.
  localparam logic FUNC_FRAME     = 1'b0;
  localparam logic FUNC_TRIP_CLR  = 1'b1;

  // The overshoot divider retires two quotient bits a cycle over a 64-bit dividend.
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DELTA,
    S_RUN,
    S_CHECK,
    S_MUL,
    S_ADD,
    S_DIV,
    S_FIN
  } wpdt_state_t;

endpackage

/* rtl/wheel_pulse_distance_timer_unit.sv */
// Wheel pulse distance timer: pulse accumulation, run timing and overshoot interpolation.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    func, raw_count, time_ms, measure_on
//   out_     output     out_valid / out_stall  pulse counts, change flags, run time
//   cfg      input      APB write/read         pulses_per_meter, target_meters,
//                                              counter_max, counter_restart
//
// A trip clear, zero count or first count passes through S_DELTA to S_FIN.
// A frame that does not finish a run goes S_DELTA, S_FIN (measurement off or run already
// done) or S_DELTA, S_RUN, S_CHECK, S_FIN, as does a frame that finishes a run on a zero
// or backward delta; one that finishes on a forward delta adds S_MUL, S_ADD and S_DIV,
// where the radix-4 divider works out the overshoot correction, before S_FIN.
// One word is in flight at a time; in_stall is high from acceptance until the result
// is loaded into the output register, and a stalled result holds the sequencer.
// Synchronous active-low reset clears all counts and the run state, loads config reset values.
`timescale 1ns / 1ps

module wheel_pulse_distance_timer_unit
  import wpdt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // Input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic [15:0]        in_raw_count,
  input  logic [31:0]        in_time_ms,
  input  logic               in_measure_on,
  // Result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_total_pulses,
  output logic signed [31:0] out_trip_pulses,
  output logic               out_total_changed,
  output logic               out_distance_changed,
  output logic               out_run_done,
  output logic               out_run_done_now,
  output logic [31:0]        out_run_time_ms,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Configuration registers.
  logic [7:0]  ppm_r;
  logic [11:0] target_m_r;
  logic [15:0] cmax_r;
  logic [15:0] restart_r;

  // Captured input word.
  logic        func_r;
  logic [15:0] raw_r;
  logic [31:0] time_r;
  logic        meas_r;

  // Architectural state.
  logic [15:0] last_count_r, last_count_nxt;
  logic        count_seen_r, count_seen_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] trip_r, trip_nxt;
  logic [31:0] start_time_r, start_time_nxt;
  logic [31:0] start_trip_r, start_trip_nxt;
  logic        reached_r, reached_nxt;
  logic [31:0] result_r, result_nxt;
  logic [31:0] prev_time_r, prev_time_nxt;

  // Working registers of the sequencer.
  wpdt_state_t          state_r, state_nxt;
  logic [15:0]          delta_r, delta_nxt;
  logic                 tchg_r, tchg_nxt;
  logic                 dchg_r, dchg_nxt;
  logic                 done_now_r, done_now_nxt;
  logic [31:0]          ftime_r, ftime_nxt;
  logic [31:0]          trav_r, trav_nxt;
  logic [31:0]          elapsed_r, elapsed_nxt;
  logic [19:0]          target_r, target_nxt;
  logic [31:0]          over_r, over_nxt;
  logic [63:0]          num_r, num_nxt;
  logic [15:0]          rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] o_total_r, o_total_nxt;
  logic [31:0] o_trip_r, o_trip_nxt;
  logic        o_tchg_r, o_tchg_nxt;
  logic        o_dchg_r, o_dchg_nxt;
  logic        o_done_r, o_done_nxt;
  logic        o_done_now_r, o_done_now_nxt;
  logic [31:0] o_time_r, o_time_nxt;

  // Combinational helpers.
  logic        in_acc;
  logic        cfg_wr;
  logic [7:0]  ppm_eff;
  logic [15:0] d16;
  logic        dneg;
  logic [15:0] dmag;
  logic [31:0] dext;
  logic [20:0] dmag20;
  logic [31:0] trip_new;
  logic        hit;
  logic [14:0] dv;
  logic [16:0] r1, r1s, r2, r2s;
  logic        q1, q2;
  logic        corr_big;
  logic [31:0] new_result;
  logic        out_free;

  assign in_acc   = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign in_stall = (state_r != S_IDLE);
  assign ppm_eff  = (ppm_r == 8'd0) ? 8'd1 : ppm_r;
  assign out_free = !out_valid_r || !out_stall;

  // Register read-back.
  always_comb begin
    unique case (paddr[3:2])
      REG_PPM:     prdata = {24'd0, ppm_r};
      REG_TARGET:  prdata = {20'd0, target_m_r};
      REG_CMAX:    prdata = {16'd0, cmax_r};
      REG_RESTART: prdata = {16'd0, restart_r};
      default:     prdata = 32'd0;
    endcase
  end

  // Pulse delta with the counter wrap rule, and its magnitude test.
  always_comb begin
    if (raw_r >= last_count_r) begin
      d16 = raw_r - last_count_r;
    end else begin
      d16 = cmax_r - last_count_r + 16'd1 + raw_r - restart_r;
    end
    dneg     = d16[15];
    dmag     = dneg ? (16'd0 - d16) : d16;
    dext     = {{16{d16[15]}}, d16};
    dmag20   = {5'd0, dmag} * 21'd20;
    trip_new = trip_r + dext;
  end

  // Target test on the travelled pulse count.
  assign hit = !trav_r[31] && (trav_r >= {12'd0, target_r}) && (start_time_r != 32'd0);

  // One radix-4 restoring step of the overshoot divider.
  always_comb begin
    dv  = delta_r[14:0];
    r1  = {rem_r, num_r[63]};
    q1  = (r1 >= {2'd0, dv});
    r1s = q1 ? (r1 - {2'd0, dv}) : r1;
    r2  = {r1s[15:0], num_r[62]};
    q2  = (r2 >= {2'd0, dv});
    r2s = q2 ? (r2 - {2'd0, dv}) : r2;
  end

  // Elapsed time less the correction, saturated at zero.
  assign corr_big   = (num_r[63:32] != 32'd0) || (num_r[31:0] >= elapsed_r);
  assign new_result = corr_big ? 32'd0 : (elapsed_r - num_r[31:0]);

  // Sequencer: next state, state updates and result loading.
  always_comb begin
    state_nxt      = state_r;
    last_count_nxt = last_count_r;
    count_seen_nxt = count_seen_r;
    total_nxt      = total_r;
    trip_nxt       = trip_r;
    start_time_nxt = start_time_r;
    start_trip_nxt = start_trip_r;
    reached_nxt    = reached_r;
    result_nxt     = result_r;
    prev_time_nxt  = prev_time_r;
    delta_nxt      = delta_r;
    tchg_nxt       = tchg_r;
    dchg_nxt       = dchg_r;
    done_now_nxt   = done_now_r;
    ftime_nxt      = ftime_r;
    trav_nxt       = trav_r;
    elapsed_nxt    = elapsed_r;
    target_nxt     = target_r;
    over_nxt       = over_r;
    num_nxt        = num_r;
    rem_nxt        = rem_r;
    div_cnt_nxt    = div_cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    o_total_nxt    = o_total_r;
    o_trip_nxt     = o_trip_r;
    o_tchg_nxt     = o_tchg_r;
    o_dchg_nxt     = o_dchg_r;
    o_done_nxt     = o_done_r;
    o_done_now_nxt = o_done_now_r;
    o_time_nxt     = o_time_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          tchg_nxt     = 1'b0;
          dchg_nxt     = 1'b0;
          done_now_nxt = 1'b0;
          state_nxt    = S_DELTA;
        end
      end

      // Classify the word and apply the delta to the counts.
      S_DELTA: begin
        state_nxt = S_FIN;
        if (func_r == FUNC_TRIP_CLR) begin
          trip_nxt = 32'd0;
        end else if (raw_r == 16'd0) begin
          last_count_nxt = 16'd0;
        end else if (!count_seen_r) begin
          last_count_nxt = raw_r;
          count_seen_nxt = 1'b1;
        end else begin
          delta_nxt      = d16;
          total_nxt      = total_r + dext;
          trip_nxt       = trip_new;
          last_count_nxt = raw_r;
          tchg_nxt       = (d16 != 16'd0);
          dchg_nxt       = (dmag20 >= {13'd0, ppm_eff});
          if (!meas_r) begin
            start_time_nxt = 32'd0;
            start_trip_nxt = 32'd0;
            reached_nxt    = 1'b0;
            result_nxt     = 32'd0;
            prev_time_nxt  = 32'd0;
          end else begin
            prev_time_nxt = time_r;
            if (!reached_r) begin
              ftime_nxt = (prev_time_r == 32'd0) ? 32'd0 : (time_r - prev_time_r);
              if ((start_time_r == 32'd0) && !dneg && (d16 != 16'd0)) begin
                start_time_nxt = time_r;
                start_trip_nxt = trip_r;
              end
              state_nxt = S_RUN;
            end
          end
        end
      end

      // Distance travelled in this run, elapsed time and pulse target.
      S_RUN: begin
        trav_nxt    = trip_r - start_trip_r;
        elapsed_nxt = time_r - start_time_r;
        target_nxt  = {8'd0, target_m_r} * {12'd0, ppm_eff};
        state_nxt   = S_CHECK;
      end

      // Target reached: correct only when the last delta was positive.
      S_CHECK: begin
        state_nxt = S_FIN;
        if (hit) begin
          reached_nxt  = 1'b1;
          done_now_nxt = 1'b1;
          over_nxt     = trav_r - {12'd0, target_r};
          num_nxt      = 64'd0;
          if (!delta_r[15] && (delta_r != 16'd0)) begin
            state_nxt = S_MUL;
          end
        end
      end

      // Overshoot times frame time.
      S_MUL: begin
        num_nxt   = {32'd0, over_r} * {32'd0, ftime_r};
        state_nxt = S_ADD;
      end

      // Add half the delta for round-to-nearest, then start the divider.
      S_ADD: begin
        num_nxt     = num_r + {49'd0, delta_r[15:1]};
        rem_nxt     = 16'd0;
        div_cnt_nxt = '0;
        state_nxt   = S_DIV;
      end

      // Two quotient bits a cycle; the quotient shifts into the dividend register.
      S_DIV: begin
        num_nxt     = {num_r[61:0], q1, q2};
        rem_nxt     = r2s[15:0];
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_FIN;
        end
      end

      // Load the result word once the output register is free.
      S_FIN: begin
        if (out_free) begin
          if (done_now_r) begin
            result_nxt = new_result;
          end
          out_valid_nxt  = 1'b1;
          o_total_nxt    = total_r;
          o_trip_nxt     = trip_r;
          o_tchg_nxt     = tchg_r;
          o_dchg_nxt     = dchg_r;
          o_done_nxt     = reached_r;
          o_done_now_nxt = done_now_r;
          o_time_nxt     = done_now_r ? new_result : result_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      ppm_r        <= PPM_RST;
      target_m_r   <= TARGET_RST;
      cmax_r       <= CMAX_RST;
      restart_r    <= RESTART_RST;
      last_count_r <= 16'd0;
      count_seen_r <= 1'b0;
      total_r      <= 32'd0;
      trip_r       <= 32'd0;
      start_time_r <= 32'd0;
      start_trip_r <= 32'd0;
      reached_r    <= 1'b0;
      result_r     <= 32'd0;
      prev_time_r  <= 32'd0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      last_count_r <= last_count_nxt;
      count_seen_r <= count_seen_nxt;
      total_r      <= total_nxt;
      trip_r       <= trip_nxt;
      start_time_r <= start_time_nxt;
      start_trip_r <= start_trip_nxt;
      reached_r    <= reached_nxt;
      result_r     <= result_nxt;
      prev_time_r  <= prev_time_nxt;
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_PPM:     ppm_r      <= pwdata[7:0];
          REG_TARGET:  target_m_r <= pwdata[11:0];
          REG_CMAX:    cmax_r     <= pwdata[15:0];
          REG_RESTART: restart_r  <= pwdata[15:0];
          default:     ppm_r      <= ppm_r;
        endcase
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_func;
      raw_r  <= in_raw_count;
      time_r <= in_time_ms;
      meas_r <= in_measure_on;
    end
    delta_r      <= delta_nxt;
    tchg_r       <= tchg_nxt;
    dchg_r       <= dchg_nxt;
    done_now_r   <= done_now_nxt;
    ftime_r      <= ftime_nxt;
    trav_r       <= trav_nxt;
    elapsed_r    <= elapsed_nxt;
    target_r     <= target_nxt;
    over_r       <= over_nxt;
    num_r        <= num_nxt;
    rem_r        <= rem_nxt;
    div_cnt_r    <= div_cnt_nxt;
    o_total_r    <= o_total_nxt;
    o_trip_r     <= o_trip_nxt;
    o_tchg_r     <= o_tchg_nxt;
    o_dchg_r     <= o_dchg_nxt;
    o_done_r     <= o_done_nxt;
    o_done_now_r <= o_done_now_nxt;
    o_time_r     <= o_time_nxt;
  end

  // Result ports.
  assign out_valid            = out_valid_r;
  assign out_total_pulses     = o_total_r;
  assign out_trip_pulses      = o_trip_r;
  assign out_total_changed    = o_tchg_r;
  assign out_distance_changed = o_dchg_r;
  assign out_run_done         = o_done_r;
  assign out_run_done_now     = o_done_now_r;
  assign out_run_time_ms      = o_time_r;

`ifndef SYNTHESIS
  // A word that finishes a run also reports the run as done.
  a_done_now_implies_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_run_done_now) |-> out_run_done)
    else $error("run_done_now without run_done");

  // The divider remainder stays below the divisor.
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < {1'b0, delta_r[14:0]}))
    else $error("divider remainder not below divisor");

  // A finished run is cleared only by a frame with measurement off.
  a_reached_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(reached_r) |-> $past(state_r == S_DELTA && !meas_r))
    else $error("run state cleared outside a non-measuring frame");
`endif

endmodule
